/* hw/rtl/lcb_pkg.sv */
`timescale 1ns / 1ps
// Package for the cursor line-edit buffer: sizes, command and status codes,
// and the item types shared by the front, the back and the top level. No dependencies.
package lcb_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] KIND_LEFT = 3'd0;
	localparam logic [2:0] KIND_RIGHT = 3'd1;
	localparam logic [2:0] KIND_BACK = 3'd2;
	localparam logic [2:0] KIND_INSERT = 3'd3;
	localparam logic [2:0] KIND_READ = 3'd4;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_BOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic       last;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

/* hw/rtl/lcb_front.sv */
`timescale 1ns / 1ps
// Front of the line-edit buffer: accepts command items, drops unknown kinds
// and keeps the rest in a short command queue. Depends on lcb_pkg.
module lcb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lcb_pkg::in_item_t item,
	output lcb_pkg::q_head_t  head,
	input  logic              pop
);

	localparam int PW = lcb_pkg::QPTR_W;
	localparam int CW = lcb_pkg::QCNT_W;

	lcb_pkg::cmd_t    queue_q [lcb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             do_pop;

	assign busy = (count_q == CW'(lcb_pkg::QUEUE_DEPTH));

	always_comb begin
		push = 1'b0;
		if (start && !busy) begin
			unique case (item.kind) inside
				lcb_pkg::KIND_LEFT, lcb_pkg::KIND_RIGHT, lcb_pkg::KIND_BACK,
				lcb_pkg::KIND_INSERT, lcb_pkg::KIND_READ: push = 1'b1;
				default: push = 1'b0;
			endcase
		end
	end

	assign do_pop = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{op: item.kind, ch: item.char_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/lcb_back.sv */
`timescale 1ns / 1ps
// Back of the line-edit buffer: holds the gap-buffer text store and the two
// cursor counts, and carries out queued commands. Depends on lcb_pkg.
module lcb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lcb_pkg::q_head_t   head,
	output logic               pop,
	output lcb_pkg::out_item_t result,
	output logic               strobe
);

	localparam int AW = lcb_pkg::ADDR_W;
	localparam int CW = lcb_pkg::CNT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOVE = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [7:0]         mem [lcb_pkg::CAPACITY];
	logic [7:0]         rdata_q;
	logic [1:0]         state_q;
	logic [CW-1:0]      lc_q;
	logic [CW-1:0]      rc_q;
	logic [CW-1:0]      idx_q;
	logic               mv_left_q;
	logic               pend_s1;
	logic               pend_last_s1;
	lcb_pkg::out_item_t out_q;
	logic               stb_q;

	logic [CW-1:0]      total;
	logic [CW-1:0]      gap;
	logic [CW-1:0]      idx_cur;
	logic [CW-1:0]      idx_map;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [7:0]         wr_data;
	logic               issue;
	logic               issue_last;

	assign total = lc_q + rc_q;
	assign gap = CW'(lcb_pkg::CAPACITY) - total;
	assign idx_cur = (state_q == S_READ) ? idx_q : '0;
	assign idx_map = (idx_cur < lc_q) ? idx_cur : idx_cur + gap;
	assign issue_last = (idx_cur + CW'(1) == total);

	always_comb begin
		pop = 1'b0;
		rd_addr = idx_map[AW-1:0];
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = head.cmd.ch;
		issue = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (head.valid && !pend_s1) begin
					pop = 1'b1;
					unique case (head.cmd.op)
						lcb_pkg::KIND_LEFT: begin
							rd_addr = AW'(lc_q - CW'(1));
						end
						lcb_pkg::KIND_RIGHT: begin
							rd_addr = AW'(CW'(lcb_pkg::CAPACITY) - rc_q);
						end
						lcb_pkg::KIND_INSERT: begin
							wr_en = (total != CW'(lcb_pkg::CAPACITY));
							wr_addr = lc_q[AW-1:0];
						end
						lcb_pkg::KIND_READ: begin
							issue = (total != '0);
						end
						default: begin
						end
					endcase
				end
			end
			S_MOVE: begin
				wr_en = 1'b1;
				wr_data = rdata_q;
				wr_addr = mv_left_q ? AW'(CW'(lcb_pkg::CAPACITY) - rc_q - CW'(1))
					: lc_q[AW-1:0];
			end
			S_READ: begin
				issue = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lc_q <= '0;
			rc_q <= '0;
			idx_q <= '0;
			mv_left_q <= 1'b0;
			pend_s1 <= 1'b0;
			pend_last_s1 <= 1'b0;
			out_q <= '0;
			stb_q <= 1'b0;
		end else begin
			stb_q <= 1'b0;
			pend_s1 <= issue;
			pend_last_s1 <= issue_last;
			if (pend_s1) begin
				stb_q <= 1'b1;
				out_q <= '{char_out: rdata_q, char_valid: 1'b1, last: pend_last_s1,
					status: lcb_pkg::ST_DONE};
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						out_q <= '{char_out: 8'd0, char_valid: 1'b0, last: 1'b1,
							status: lcb_pkg::ST_DONE};
						unique case (head.cmd.op)
							lcb_pkg::KIND_LEFT: begin
								if (lc_q == '0) begin
									stb_q <= 1'b1;
									out_q.status <= lcb_pkg::ST_BOUND;
								end else begin
									mv_left_q <= 1'b1;
									state_q <= S_MOVE;
								end
							end
							lcb_pkg::KIND_RIGHT: begin
								if (rc_q == '0) begin
									stb_q <= 1'b1;
									out_q.status <= lcb_pkg::ST_BOUND;
								end else begin
									mv_left_q <= 1'b0;
									state_q <= S_MOVE;
								end
							end
							lcb_pkg::KIND_BACK: begin
								stb_q <= 1'b1;
								if (lc_q == '0) begin
									out_q.status <= lcb_pkg::ST_BOUND;
								end else begin
									lc_q <= lc_q - CW'(1);
								end
							end
							lcb_pkg::KIND_INSERT: begin
								stb_q <= 1'b1;
								if (wr_en) begin
									lc_q <= lc_q + CW'(1);
								end else begin
									out_q.status <= lcb_pkg::ST_FULL;
								end
							end
							lcb_pkg::KIND_READ: begin
								if (total == '0) begin
									stb_q <= 1'b1;
								end else begin
									idx_q <= CW'(1);
									if (!issue_last) begin
										state_q <= S_READ;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_MOVE: begin
					stb_q <= 1'b1;
					out_q <= '{char_out: 8'd0, char_valid: 1'b0, last: 1'b1,
						status: lcb_pkg::ST_DONE};
					if (mv_left_q) begin
						lc_q <= lc_q - CW'(1);
						rc_q <= rc_q + CW'(1);
					end else begin
						lc_q <= lc_q + CW'(1);
						rc_q <= rc_q - CW'(1);
					end
					state_q <= S_IDLE;
				end
				S_READ: begin
					idx_q <= idx_q + CW'(1);
					if (issue_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result = out_q;
	assign strobe = stb_q;

endmodule

/* hw/rtl/cursor_line_edit_buffer.sv */
`timescale 1ns / 1ps
// Top level of the cursor line-edit buffer: joins the command front and the
// gap-buffer back. Depends on lcb_pkg, lcb_front and lcb_back.
//
// Channel   Signals                 Direction  Handshake
// command   start, busy, item       in         taken when start is high and busy is low
// result    strobe, result          out        one strobe per item, cannot be held off
//
// Accepted commands wait in a four-entry queue; busy is high only while it is full.
// Backspace and insert give their result in the next cycle.
// Cursor moves read a character on dispatch and write it across the gap in the move state.
// A read-out gives its characters in order; the first goes through the read-data register
// and then the result register, and the rest follow one per cycle.
// Reset clears the cursor counts and the queue; the text store needs no clearing.
module cursor_line_edit_buffer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lcb_pkg::in_item_t  item,
	output lcb_pkg::out_item_t result,
	output logic               strobe
);

	lcb_pkg::q_head_t head;
	logic             pop;

	lcb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.head   (head),
		.pop    (pop)
	);

	lcb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result),
		.strobe (strobe)
	);

endmodule

/* tb/sv/cursor_line_edit_buffer_monitor.sv */
`timescale 1ns / 1ps
// Monitor for the cursor line-edit buffer: watches the command and result channels,
// predicts each result from its own gap-buffer copy and counts mismatches.
// Depends on lcb_pkg.
module cursor_line_edit_buffer_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  lcb_pkg::in_item_t  item,
	input  logic               strobe,
	input  lcb_pkg::out_item_t result,
	output int unsigned        pending,
	output int unsigned        failures
);

	logic [7:0] gap_text [lcb_pkg::CAPACITY];
	int unsigned n_before;
	int unsigned n_after;
	lcb_pkg::out_item_t due_results [$];
	int unsigned mismatches;

	function automatic void apply_edit(input lcb_pkg::in_item_t cmd);
		lcb_pkg::out_item_t r;
		int unsigned total;
		int unsigned pos;
		r = '0;
		r.last = 1'b1;
		r.status = lcb_pkg::ST_DONE;
		total = n_before + n_after;
		case (cmd.kind)
			lcb_pkg::KIND_LEFT: begin
				if (n_before == 0) begin
					r.status = lcb_pkg::ST_BOUND;
				end else begin
					n_before--;
					n_after++;
					gap_text[lcb_pkg::CAPACITY - n_after] = gap_text[n_before];
				end
			end
			lcb_pkg::KIND_RIGHT: begin
				if (n_after == 0) begin
					r.status = lcb_pkg::ST_BOUND;
				end else begin
					gap_text[n_before] = gap_text[lcb_pkg::CAPACITY - n_after];
					n_after--;
					n_before++;
				end
			end
			lcb_pkg::KIND_BACK: begin
				if (n_before == 0) begin
					r.status = lcb_pkg::ST_BOUND;
				end else begin
					n_before--;
				end
			end
			lcb_pkg::KIND_INSERT: begin
				if (total >= lcb_pkg::CAPACITY) begin
					r.status = lcb_pkg::ST_FULL;
				end else begin
					gap_text[n_before] = cmd.char_in;
					n_before++;
				end
			end
			lcb_pkg::KIND_READ: begin
				if (total != 0) begin
					for (int unsigned i = 0; i < total; i++) begin
						pos = (i < n_before) ? i
							: lcb_pkg::CAPACITY - n_after + (i - n_before);
						r.char_out = gap_text[pos];
						r.char_valid = 1'b1;
						r.last = (i + 1 == total);
						due_results.push_back(r);
					end
					return;
				end
			end
			default: begin
				return;
			end
		endcase
		due_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcb_pkg::out_item_t want;
		if (!arst_n) begin
			n_before = 0;
			n_after = 0;
			due_results.delete();
			mismatches = 0;
			pending <= 0;
			failures <= 0;
		end else begin
			if (strobe) begin
				if (due_results.size() == 0) begin
					$error("result with nothing expected: %p", result);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (result.char_out !== want.char_out) begin
						$error("char_out: expected %0d, got %0d", want.char_out, result.char_out);
						mismatches++;
					end
					if (result.char_valid !== want.char_valid) begin
						$error("char_valid: expected %0d, got %0d", want.char_valid,
							result.char_valid);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				apply_edit(item);
			end
			pending <= due_results.size();
			failures <= mismatches;
		end
	end

endmodule

/* tb/sv/cursor_line_edit_buffer_test.sv */
`timescale 1ns / 1ps
// Testbench top for the cursor line-edit buffer: drives edit and read-out commands,
// runs the monitor beside the block and gives the verdict.
// Depends on lcb_pkg, cursor_line_edit_buffer and cursor_line_edit_buffer_monitor.
module cursor_line_edit_buffer_test;

	localparam logic [2:0] KIND_MAX = '1;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 200;

	typedef enum {GROW, SHRINK, WANDER} edit_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lcb_pkg::in_item_t item = '0;
	lcb_pkg::out_item_t result;
	logic strobe;
	int unsigned pending;
	int unsigned failures;
	bit idle_on = 1'b1;
	int stall_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cursor_line_edit_buffer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.result (result),
		.strobe (strobe)
	);

	cursor_line_edit_buffer_monitor i_monitor (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.strobe   (strobe),
		.result   (result),
		.pending  (pending),
		.failures (failures)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("cursor_line_edit_buffer_test: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_cmd(input logic [2:0] k, input logic [7:0] c);
		while (idle_on && $urandom_range(99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= '{kind: k, char_in: c};
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [2:0] pick_kind(input edit_mode_t m);
		int unsigned r;
		r = $urandom_range(99);
		case (m)
			GROW:
				return (r < 80) ? lcb_pkg::KIND_INSERT : (r < 87) ? lcb_pkg::KIND_LEFT :
					(r < 94) ? lcb_pkg::KIND_RIGHT : (r < 97) ? lcb_pkg::KIND_BACK :
					lcb_pkg::KIND_READ;
			SHRINK:
				return (r < 45) ? lcb_pkg::KIND_BACK : (r < 65) ? lcb_pkg::KIND_LEFT :
					(r < 80) ? lcb_pkg::KIND_RIGHT : (r < 92) ? lcb_pkg::KIND_INSERT :
					lcb_pkg::KIND_READ;
			default:
				return (r < 25) ? lcb_pkg::KIND_LEFT : (r < 50) ? lcb_pkg::KIND_RIGHT :
					(r < 62) ? lcb_pkg::KIND_BACK : (r < 85) ? lcb_pkg::KIND_INSERT :
					lcb_pkg::KIND_READ;
		endcase
	endfunction

	initial begin
		int sent;
		int seg_left;
		edit_mode_t mode;
		bit paused_mid;
		sent = 0;
		paused_mid = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Boundary cases on the empty line, then a short edit session, unknown kinds and a read-out.
		send_cmd(lcb_pkg::KIND_READ, 8'hA5);
		send_cmd(lcb_pkg::KIND_LEFT, 8'h00);
		send_cmd(lcb_pkg::KIND_RIGHT, 8'hFF);
		send_cmd(lcb_pkg::KIND_BACK, 8'h5A);
		send_cmd(lcb_pkg::KIND_INSERT, 8'h00);
		send_cmd(lcb_pkg::KIND_INSERT, 8'hFF);
		send_cmd(lcb_pkg::KIND_INSERT, "L");
		send_cmd(lcb_pkg::KIND_INSERT, "D");
		send_cmd(lcb_pkg::KIND_READ, 8'h00);
		send_cmd(lcb_pkg::KIND_LEFT, 8'h00);
		send_cmd(lcb_pkg::KIND_LEFT, 8'h00);
		send_cmd(lcb_pkg::KIND_INSERT, "B");
		send_cmd(lcb_pkg::KIND_RIGHT, 8'h00);
		send_cmd(lcb_pkg::KIND_BACK, 8'h00);
		send_cmd(lcb_pkg::KIND_INSERT, "P");
		repeat (5) send_cmd(lcb_pkg::KIND_LEFT, 8'h00);
		send_cmd(lcb_pkg::KIND_BACK, 8'h00);
		send_cmd(lcb_pkg::KIND_READ, 8'h00);
		repeat (5) send_cmd(lcb_pkg::KIND_RIGHT, 8'h00);
		send_cmd(lcb_pkg::KIND_READ + 3'd1, 8'h11);
		send_cmd(lcb_pkg::KIND_READ + 3'd2, 8'h22);
		send_cmd(KIND_MAX, 8'h33);
		send_cmd(lcb_pkg::KIND_READ, 8'h00);
		wait_drained();

		// The first segment fills the line so that inserts get dropped.
		mode = GROW;
		seg_left = 80;
		while (sent < ITEM_TARGET) begin
			if (seg_left == 0) begin
				mode = edit_mode_t'($urandom_range(2));
				seg_left = $urandom_range(10, 40);
			end
			idle_on = !(sent >= 100 && sent < 150);
			if (!paused_mid && sent >= 130) begin
				wait_drained();
				paused_mid = 1'b1;
			end
			if ($urandom_range(99) < 4) begin
				send_cmd(3'($urandom_range(lcb_pkg::KIND_READ + 1, KIND_MAX)),
					8'($urandom_range(255)));
			end else begin
				send_cmd(pick_kind(mode), 8'($urandom_range(255)));
				sent++;
				seg_left--;
			end
		end
		send_cmd(lcb_pkg::KIND_READ, 8'h00);

		wait_drained();
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("cursor_line_edit_buffer_test: done, clean");
		end else begin
			$display("cursor_line_edit_buffer_test: done, errors");
		end
		$finish;
	end

endmodule
